[rtl/core/ccdcal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccdcal_pkg
// Shared constants and types for the pixel calibration pipeline.
// ----------------------------------------------------------------------------
package ccdcal_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 4096;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned NUM_W  = 50;   // signed numerator, Q.8
    localparam int unsigned DEN_W  = 40;   // unsigned denominator, Q.22
    localparam int unsigned DIVN_W = 64;   // numerator magnitude after * 2^14
    localparam int unsigned ADDR_W = 24;

    localparam logic [15:0] FLAT_HALF = 16'd8192;

    // Register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_EXPO   = 3'd2;
    localparam logic [2:0] REG_B_TL   = 3'd3;
    localparam logic [2:0] REG_B_BL   = 3'd4;
    localparam logic [2:0] REG_B_TR   = 3'd5;
    localparam logic [2:0] REG_B_BR   = 3'd6;
    localparam logic [2:0] REG_ORIENT = 3'd7;

    // Item context carried alongside the divider
    typedef struct packed {
        logic                valid_px;
        logic                zero_den;
        logic                neg;
        logic                nz_num;
        logic [ADDR_W-1:0]   addr;
    } t_side;

endpackage
`default_nettype wire

[rtl/core/ccdcal_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccdcal_front
// Front stages: quadrant level, numerator, denominator and output address.
// ----------------------------------------------------------------------------
module ccdcal_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire  signed [24:0]           i_raw,
    input  wire  signed [24:0]           i_bias,
    input  wire  signed [24:0]           i_dark,
    input  wire         [15:0]           i_flat,
    input  wire         [7:0]            i_dither,
    input  wire         [11:0]           i_row,
    input  wire         [11:0]           i_col,
    input  wire         [12:0]           i_width,
    input  wire         [12:0]           i_height,
    input  wire         [23:0]           i_expo,
    input  wire  signed [24:0]           i_b_tl,
    input  wire  signed [24:0]           i_b_bl,
    input  wire  signed [24:0]           i_b_tr,
    input  wire  signed [24:0]           i_b_br,
    input  wire         [2:0]            i_orient,
    output logic                         o_valid,
    output logic        [ccdcal_pkg::DIVN_W-1:0] o_num_mag,
    output logic        [ccdcal_pkg::DEN_W-1:0]  o_den,
    output ccdcal_pkg::t_side            o_side
);
    // stage 1: level, partial sums, products, flipped indices
    logic               r1_v;
    logic signed [27:0] r1_sum;
    logic signed [48:0] r1_dprod;
    logic        [39:0] r1_den;
    logic               r1_vp;
    logic        [23:0] r1_r;
    logic        [23:0] r1_c;
    logic               r1_tr;
    logic        [12:0] r1_w;
    logic        [12:0] r1_h;

    logic               top, left, rflip, cflip;
    logic signed [24:0] level;
    logic signed [27:0] sum;

    always_comb begin
        top   = {1'b0, i_row} < (i_height >> 1);
        left  = {1'b0, i_col} < (i_width >> 1);
        level = top ? (left ? i_b_tl : i_b_tr) : (left ? i_b_bl : i_b_br);
        rflip = (i_orient == 3'd1) || (i_orient == 3'd2) || (i_orient == 3'd4)
                || (i_orient == 3'd7);
        cflip = (i_orient == 3'd2) || (i_orient == 3'd3) || (i_orient == 3'd6)
                || (i_orient == 3'd7);
        sum   = 28'(i_raw) + 28'(signed'({1'b0, i_dither})) - 28'(i_bias)
                - 28'(level);
    end

    // flipped indices wrap at the address width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_sum   <= sum;
        r1_dprod <= i_dark * signed'({1'b0, i_expo});
        r1_den   <= i_expo * i_flat;
        r1_vp    <= i_flat > ccdcal_pkg::FLAT_HALF;
        r1_r     <= rflip ? 24'({11'd0, i_height} - 24'd1 - 24'(i_row)) : 24'(i_row);
        r1_c     <= cflip ? 24'({11'd0, i_width} - 24'd1 - 24'(i_col)) : 24'(i_col);
        r1_tr    <= i_orient[0];
        r1_w     <= i_width;
        r1_h     <= i_height;
    end

    // stage 2: numerator and address products
    logic               r2_v;
    logic signed [49:0] r2_num;
    logic        [39:0] r2_den;
    logic               r2_vp;
    logic        [23:0] r2_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_num  <= (50'(r1_sum) <<< 8) - 50'(r1_dprod);
        r2_den  <= r1_den;
        r2_vp   <= r1_vp;
        r2_addr <= r1_tr ? 24'(r1_r + r1_h * r1_c) : 24'(r1_c + r1_w * r1_r);
    end

    // stage 3: magnitude and flags
    logic [49:0] mag;
    assign mag = r2_num[49] ? 50'(-r2_num) : 50'(r2_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r2_v;
        end
        o_num_mag       <= {mag, 14'd0};
        o_den           <= r2_den;
        o_side.valid_px <= r2_vp;
        o_side.zero_den <= (r2_den == '0);
        o_side.neg      <= r2_num[49];
        o_side.nz_num   <= (r2_num != '0);
        o_side.addr     <= r2_addr;
    end
endmodule
`default_nettype wire

[rtl/core/ccdcal_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccdcal_div
// Pipelined restoring divider, one quotient bit per stage, saturating.
// ----------------------------------------------------------------------------
module ccdcal_div (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  wire  [ccdcal_pkg::DIVN_W-1:0]      i_num,
    input  wire  [ccdcal_pkg::DEN_W-1:0]       i_den,
    input  ccdcal_pkg::t_side                  i_side,
    output logic                               o_valid,
    output logic [31:0]                        o_value,
    output logic                               o_pv,
    output logic [ccdcal_pkg::ADDR_W-1:0]      o_addr
);
    localparam int unsigned N = ccdcal_pkg::DIVN_W;
    localparam int unsigned D = ccdcal_pkg::DEN_W;

    logic                    r_v   [N+1];
    logic [N-1:0]            r_q   [N+1];
    logic [D:0]              r_rem [N+1];
    logic [D-1:0]            r_den [N+1];
    ccdcal_pkg::t_side       r_sd  [N+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_q[0]   = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_sd[0]  = i_side;
    end

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic [D+1:0] sh;
        logic [D+1:0] df;
        assign sh = {r_rem[k], r_q[k][N-1]};
        assign df = sh - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_q[k+1]   <= {r_q[k][N-2:0], ~df[D+1]};
            r_rem[k+1] <= df[D+1] ? sh[D:0] : df[D:0];
            r_den[k+1] <= r_den[k];
            r_sd[k+1]  <= r_sd[k];
        end
    end

    // saturation and sign
    logic [N-1:0] q;
    logic [31:0]  val;
    always_comb begin
        q = r_q[N];
        if (!r_sd[N].valid_px) begin
            val = '0;
        end else if (r_sd[N].zero_den) begin
            val = !r_sd[N].nz_num ? 32'd0 : (r_sd[N].neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end else if (r_sd[N].neg) begin
            val = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        end else begin
            val = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[N];
        end
        o_value <= val;
        o_pv    <= r_sd[N].valid_px;
        o_addr  <= r_sd[N].addr;
    end
endmodule
`default_nettype wire

[rtl/core/ccd_pixel_calibrate_reorient_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pixel_calibrate_reorient_unit
// Bias, dark and flat calibration of one pixel per clock, with reoriented
// output address.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | i_start / o_busy     | raw, bias, dark, flat, dither, row, column
//  config  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  result  | o_strobe             | calibrated value, valid flag, address
//
//  One pixel is taken every clock; o_busy is held low. The path runs through
//  three front stages, one divider stage per quotient bit (64) and an output
//  register. The divider chain sets the latency.
//  Reset clears the valid bits and loads the register defaults.
//  The receiver cannot stall, so the pipeline never halts.
// ----------------------------------------------------------------------------
module ccd_pixel_calibrate_reorient_unit #(
    parameter int unsigned MAX_WIDTH  = ccdcal_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = ccdcal_pkg::MAX_HEIGHT_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    output logic               o_busy,
    input  wire  signed [24:0] i_raw_value,
    input  wire  signed [24:0] i_bias_value,
    input  wire  signed [24:0] i_dark_value,
    input  wire         [15:0] i_flat_value,
    input  wire         [7:0]  i_dither,
    input  wire         [11:0] i_row_index,
    input  wire         [11:0] i_column_index,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire         [2:0]  i_cfg_index,
    input  wire         [31:0] i_cfg_data,
    output logic               o_strobe,
    output logic signed [31:0] o_calibrated_value,
    output logic               o_pixel_valid,
    output logic        [23:0] o_output_address
);
    // register file
    logic [12:0]        r_width, r_height;
    logic [23:0]        r_expo;
    logic signed [24:0] r_b_tl, r_b_bl, r_b_tr, r_b_br;
    logic [2:0]         r_orient;

    // clamp a dimension write to the build maximum
    function automatic logic [12:0] clamp_dim(input logic [12:0] v,
                                              input logic [16:0] mx);
        return ({4'd0, v} > mx) ? 13'(mx) : v;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_dim(13'd4096, 17'(MAX_WIDTH));
            r_height <= clamp_dim(13'd4096, 17'(MAX_HEIGHT));
            r_expo   <= 24'd256;
            r_b_tl   <= '0;
            r_b_bl   <= '0;
            r_b_tr   <= '0;
            r_b_br   <= '0;
            r_orient <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ccdcal_pkg::REG_WIDTH:  r_width  <= clamp_dim(i_cfg_data[12:0],
                                                             17'(MAX_WIDTH));
                ccdcal_pkg::REG_HEIGHT: r_height <= clamp_dim(i_cfg_data[12:0],
                                                             17'(MAX_HEIGHT));
                ccdcal_pkg::REG_EXPO:   r_expo   <= i_cfg_data[23:0];
                ccdcal_pkg::REG_B_TL:   r_b_tl   <= i_cfg_data[24:0];
                ccdcal_pkg::REG_B_BL:   r_b_bl   <= i_cfg_data[24:0];
                ccdcal_pkg::REG_B_TR:   r_b_tr   <= i_cfg_data[24:0];
                ccdcal_pkg::REG_B_BR:   r_b_br   <= i_cfg_data[24:0];
                ccdcal_pkg::REG_ORIENT: r_orient <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic                                fr_valid;
    logic [ccdcal_pkg::DIVN_W-1:0]       fr_num;
    logic [ccdcal_pkg::DEN_W-1:0]        fr_den;
    ccdcal_pkg::t_side                   fr_side;

    // front end: level pick, numerator, denominator, address
    ccdcal_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_start),
        .i_raw(i_raw_value), .i_bias(i_bias_value), .i_dark(i_dark_value),
        .i_flat(i_flat_value), .i_dither(i_dither), .i_row(i_row_index),
        .i_col(i_column_index), .i_width(r_width), .i_height(r_height),
        .i_expo(r_expo), .i_b_tl(r_b_tl), .i_b_bl(r_b_bl), .i_b_tr(r_b_tr),
        .i_b_br(r_b_br), .i_orient(r_orient),
        .o_valid(fr_valid), .o_num_mag(fr_num), .o_den(fr_den), .o_side(fr_side)
    );

    logic [31:0] dv_value;

    // quotient pipeline with saturation
    ccdcal_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(fr_valid),
        .i_num(fr_num), .i_den(fr_den), .i_side(fr_side),
        .o_valid(o_strobe), .o_value(dv_value), .o_pv(o_pixel_valid),
        .o_addr(o_output_address)
    );

    assign o_calibrated_value = signed'(dv_value);
endmodule
`default_nettype wire

[rtl/core/ccdcal_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccdcal_checker
// Port-level checks on the calibration unit.
// ----------------------------------------------------------------------------
module ccdcal_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_busy,
    input wire        o_strobe,
    input wire        o_pixel_valid,
    input wire [31:0] o_calibrated_value
);
    // an invalid pixel always reports zero
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_pixel_valid) |-> (o_calibrated_value == 32'd0))
        else $error("invalid pixel with nonzero value");

    // the unit never holds off input
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_strobe) else $error("strobe after reset");
endmodule

bind ccd_pixel_calibrate_reorient_unit ccdcal_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy), .o_strobe(o_strobe),
    .o_pixel_valid(o_pixel_valid), .o_calibrated_value(o_calibrated_value)
);
`default_nettype wire
